### rtl/core/display_list_page_renderer_assert.svh
// Assertion macros used by the renderer sequencer.
`ifndef DISPLAY_LIST_PAGE_RENDERER_ASSERT_SVH
`define DISPLAY_LIST_PAGE_RENDERER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DLPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DLPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DLPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DLPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/dlpr_pkg.sv
// Types, codes and font table of the display list page renderer.
package dlpr_pkg;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_OPEN   = 2'd1;
    localparam logic [1:0] REQ_APPEND = 2'd2;
    localparam logic [1:0] REQ_RENDER = 2'd3;

    localparam logic [1:0] KIND_SMALL  = 2'd0;
    localparam logic [1:0] KIND_DOUBLE = 2'd1;
    localparam logic [1:0] KIND_FILL   = 2'd2;
    localparam logic [1:0] KIND_ERASE  = 2'd3;

    localparam logic [7:0] GLYPH_FIRST = 8'h20;
    localparam logic [7:0] GLYPH_LAST  = 8'h7F;
    localparam logic [7:0] COLS        = 8'd64;
    localparam logic [5:0] LAST_COL    = 6'd63;
    localparam logic [3:0] SMALL_COLS  = 4'd6;
    localparam logic [3:0] DOUBLE_COLS = 4'd10;
    localparam logic [7:0] SMALL_ADV   = 8'd6;
    localparam logic [7:0] DOUBLE_ADV  = 8'd12;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] entry_kind;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] rect_w;
        logic [7:0] rect_h;
        logic [7:0] char_code;
        logic [3:0] page_index;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
    } t_entry;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic ent_rd;
        logic ent_lat;
        logic chr_rd;
        logic chr_lat;
        logic pix_rd;
        logic pix_wr;
        logic pix_skip;
        logic next_chr;
        logic next_ent;
        logic emit_rd;
        logic emit_ld;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic ent_more;
        logic ent_skip;
        logic is_rect;
        logic chr_more;
        logic pix_more;
        logic col_ok;
        logic emit_last;
    } t_stat;

    // 5x7 glyphs, column 0 in the top byte
    localparam logic [39:0] FONT [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'h0000000000
    };

    function automatic logic [6:0] glyph_index(input logic [7:0] code);
        logic [7:0] d;
        d = code - GLYPH_FIRST;
        if (code < GLYPH_FIRST || code > GLYPH_LAST) begin
            return 7'd0;
        end
        return d[6:0];
    endfunction

    function automatic logic [7:0] glyph_col(input logic [39:0] g, input logic [2:0] k);
        case (k)
            3'd0: return g[39:32];
            3'd1: return g[31:24];
            3'd2: return g[23:16];
            3'd3: return g[15:8];
            3'd4: return g[7:0];
            default: return 8'h00;
        endcase
    endfunction

endpackage

### rtl/core/dlpr_ctrl.sv
// Sequencer for list requests, page clear, entry drawing and column output.
module dlpr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_is_render,
    input  logic           i_out_ready,
    input  dlpr_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output dlpr_pkg::t_cmd o_cmd
);
    import dlpr_pkg::*;
`include "display_list_page_renderer_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_ENT_RD, S_ENT_LAT, S_ENT_GO, S_CHR_RD, S_CHR_LAT,
        S_PIX_RD, S_PIX_WR, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    if (i_is_render) n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                w_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) n_state = S_ENT_RD;
            end
            S_ENT_RD: begin
                if (i_stat.ent_more) begin
                    w_cmd.ent_rd = 1'b1;
                    n_state = S_ENT_LAT;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_ENT_LAT: begin
                w_cmd.ent_lat = 1'b1;
                n_state = S_ENT_GO;
            end
            S_ENT_GO: begin
                if (i_stat.ent_skip) begin
                    w_cmd.next_ent = 1'b1;
                    n_state = S_ENT_RD;
                end else if (i_stat.is_rect) begin
                    n_state = S_PIX_RD;
                end else begin
                    n_state = S_CHR_RD;
                end
            end
            S_CHR_RD: begin
                if (i_stat.chr_more) begin
                    w_cmd.chr_rd = 1'b1;
                    n_state = S_CHR_LAT;
                end else begin
                    w_cmd.next_ent = 1'b1;
                    n_state = S_ENT_RD;
                end
            end
            S_CHR_LAT: begin
                w_cmd.chr_lat = 1'b1;
                n_state = S_PIX_RD;
            end
            S_PIX_RD: begin
                if (!i_stat.pix_more) begin
                    if (i_stat.is_rect) begin
                        w_cmd.next_ent = 1'b1;
                        n_state = S_ENT_RD;
                    end else begin
                        w_cmd.next_chr = 1'b1;
                        n_state = S_CHR_RD;
                    end
                end else if (i_stat.col_ok) begin
                    w_cmd.pix_rd = 1'b1;
                    n_state = S_PIX_WR;
                end else begin
                    w_cmd.pix_skip = 1'b1;
                end
            end
            S_PIX_WR: begin
                w_cmd.pix_wr = 1'b1;
                n_state = S_PIX_RD;
            end
            S_EMIT_RD: begin
                w_cmd.emit_rd = 1'b1;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                w_cmd.emit_ld = 1'b1;
                n_valid = 1'b1;
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    n_valid = 1'b0;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        w_cmd.emit_rd = 1'b1;
                        n_state = S_EMIT_LD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;
    assign o_cmd       = w_cmd;

    `DLPR_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_in_ready, !o_out_valid, "output while idle")
    `DLPR_ASSERT_NXT(a_render_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_is_render,
        !o_in_ready, "render did not start")
    `DLPR_ASSERT_NXT(a_last_frees, i_clk, i_rst_n,
        o_out_valid && i_out_ready && i_stat.emit_last,
        o_in_ready && !o_out_valid, "no return to idle after last column")

endmodule

### rtl/core/dlpr_datapath.sv
// Entry, text and page memories with the per-column drawing logic.
module dlpr_datapath #(
    parameter int MAX_ENTRIES = 16,
    parameter int TEXT_LEN    = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dlpr_pkg::t_req  i_req,
    input  dlpr_pkg::t_cmd  i_cmd,
    output dlpr_pkg::t_stat o_stat,
    output logic [7:0]      o_col_byte,
    output logic [5:0]      o_col_index,
    output logic            o_col_last
);
    import dlpr_pkg::*;

    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int LW  = $clog2(TEXT_LEN);
    localparam int TD  = MAX_ENTRIES * TEXT_LEN;
    localparam int TAW = $clog2(TD);

    t_entry      r_ent_mem [MAX_ENTRIES];
    logic [LW-1:0] r_len_mem [MAX_ENTRIES];
    logic [7:0]  r_txt_mem [TD];
    logic [7:0]  r_buf_mem [64];
    t_entry      r_ent_q;
    logic [LW-1:0] r_len_q;
    logic [7:0]  r_txt_q;
    logic [7:0]  r_buf_q;

    logic [CW-1:0] r_count, r_ent;
    logic [LW-1:0] r_cur_len, r_len, r_chr;
    logic [3:0]  r_page;
    logic [1:0]  r_kind;
    logic [7:0]  r_ey, r_eh, r_cx, r_col;
    logic [6:0]  r_xlim;
    logic [3:0]  r_sub;
    logic [39:0] r_glyph;
    logic [5:0]  r_bcol;
    logic [7:0]  r_out_byte;
    logic [5:0]  r_out_idx;
    logic        r_out_last;

    logic          w_open, w_app;
    logic [CW-1:0] w_newest_c;
    logic [EW-1:0] w_newest;
    logic [TAW-1:0] w_txt_wa, w_txt_ra;
    logic [EW-1:0] w_len_wa;
    logic [LW-1:0] w_len_wd;
    logic [5:0]    w_buf_wa, w_buf_ra;
    logic [7:0]    w_buf_wd;
    logic [7:0]    w_xend;
    logic [7:0]    w_ps;
    logic [8:0]    w_bot, w_row;
    logic [7:0]    w_rmask, w_dmask, w_gb, w_wbyte;
    logic [2:0]    w_k;
    logic [13:0]   w_exp;
    logic [29:0]   w_v, w_sh;
    logic [9:0]    w_off;
    logic          w_small;

    assign w_open     = i_cmd.load && i_req.req_type == REQ_OPEN
                        && r_count < CW'(MAX_ENTRIES);
    assign w_app      = i_cmd.load && i_req.req_type == REQ_APPEND && r_count != '0
                        && r_cur_len < LW'(TEXT_LEN - 1);
    assign w_newest_c = r_count - CW'(1);
    assign w_newest   = w_newest_c[EW-1:0];
    assign w_txt_wa   = TAW'(w_newest * TEXT_LEN) + TAW'(r_cur_len);
    assign w_txt_ra   = TAW'(r_ent[EW-1:0] * TEXT_LEN) + TAW'(r_chr);
    assign w_len_wa   = w_open ? r_count[EW-1:0] : w_newest;
    assign w_len_wd   = w_open ? '0 : r_cur_len + LW'(1);

    always_ff @(posedge i_clk) begin
        if (w_open) begin
            r_ent_mem[r_count[EW-1:0]] <= '{kind: i_req.entry_kind, x: i_req.pos_x,
                                            y: i_req.pos_y, w: i_req.rect_w,
                                            h: i_req.rect_h};
        end
        if (i_cmd.ent_rd) begin
            r_ent_q <= r_ent_mem[r_ent[EW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_open || w_app) begin
            r_len_mem[w_len_wa] <= w_len_wd;
        end
        if (i_cmd.ent_rd) begin
            r_len_q <= r_len_mem[r_ent[EW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_app) begin
            r_txt_mem[w_txt_wa] <= i_req.char_code;
        end
        if (i_cmd.chr_rd) begin
            r_txt_q <= r_txt_mem[w_txt_ra];
        end
    end

    assign w_buf_wa = i_cmd.clr_wr ? r_bcol : r_col[5:0];
    assign w_buf_wd = i_cmd.clr_wr ? 8'h00 : w_wbyte;
    assign w_buf_ra = i_cmd.emit_rd ? r_bcol : r_col[5:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr || i_cmd.pix_wr) begin
            r_buf_mem[w_buf_wa] <= w_buf_wd;
        end
        if (i_cmd.pix_rd || i_cmd.emit_rd) begin
            r_buf_q <= r_buf_mem[w_buf_ra];
        end
    end

    // rectangle rows within this page
    assign w_ps  = {1'b0, r_page, 3'b000};
    assign w_bot = {1'b0, r_ey} + {1'b0, r_eh};
    always_comb begin
        w_row = '0;
        for (int j = 0; j < 8; j++) begin
            w_row = {1'b0, w_ps} + 9'(j);
            w_rmask[j] = (w_row >= {1'b0, r_ey}) && (w_row < w_bot);
        end
    end

    assign w_small = (r_kind == KIND_SMALL);
    assign w_k     = w_small ? r_sub[2:0] : {1'b0, r_sub[3:2] == 2'b11 ? 2'b11 : r_sub[2:1]}
                     | (w_small ? 3'b000 : {r_sub[3], 2'b00});
    assign w_gb    = glyph_col(r_glyph, w_k);

    // double text: each glyph row covers two pixel rows starting at r_ey
    always_comb begin
        for (int r = 0; r < 7; r++) begin
            w_exp[2*r]   = w_gb[r];
            w_exp[2*r+1] = w_gb[r];
        end
    end
    assign w_v     = {8'h00, w_exp, 8'h00};
    assign w_off   = {2'b00, w_ps} + 10'd8 - {2'b00, r_ey};
    assign w_sh    = w_v >> w_off[4:0];
    assign w_dmask = (!w_off[9] && w_off <= 10'd21) ? w_sh[7:0] : 8'h00;

    always_comb begin
        case (r_kind)
            KIND_SMALL:  w_wbyte = {1'b0, w_gb[6:0]};
            KIND_DOUBLE: w_wbyte = r_buf_q | w_dmask;
            KIND_FILL:   w_wbyte = r_buf_q | w_rmask;
            default:     w_wbyte = r_buf_q & ~w_rmask;
        endcase
    end

    assign w_xend = r_ent_q.x + r_ent_q.w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load && i_req.req_type == REQ_CLEAR) begin
            r_count <= '0;
        end else if (w_open) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_open) begin
            r_cur_len <= '0;
        end else if (w_app) begin
            r_cur_len <= r_cur_len + LW'(1);
        end
        if (i_cmd.load) begin
            r_page <= i_req.page_index;
            r_ent  <= '0;
            r_bcol <= '0;
        end
        if (i_cmd.clr_wr) begin
            r_bcol <= r_bcol + 6'd1;
        end
        if (i_cmd.ent_lat) begin
            r_kind <= r_ent_q.kind;
            r_ey   <= r_ent_q.y;
            r_eh   <= r_ent_q.h;
            r_len  <= r_len_q;
            r_chr  <= '0;
            r_cx   <= r_ent_q.x;
            r_col  <= r_ent_q.x;
            r_sub  <= '0;
            r_xlim <= (w_xend > COLS) ? 7'd64 : w_xend[6:0];
        end
        if (i_cmd.chr_lat) begin
            r_glyph <= FONT[glyph_index(r_txt_q)];
            r_sub   <= '0;
            r_col   <= r_cx;
        end
        if (i_cmd.pix_wr || i_cmd.pix_skip) begin
            r_col <= r_col + 8'd1;
            r_sub <= r_sub + 4'd1;
        end
        if (i_cmd.next_chr) begin
            r_chr <= r_chr + LW'(1);
            r_cx  <= r_cx + (w_small ? SMALL_ADV : DOUBLE_ADV);
        end
        if (i_cmd.next_ent) begin
            r_ent <= r_ent + CW'(1);
        end
        if (i_cmd.emit_rd) begin
            r_bcol <= r_bcol + 6'd1;
        end
        if (i_cmd.emit_ld) begin
            r_out_byte <= r_buf_q;
            r_out_idx  <= r_bcol - 6'd1;
            r_out_last <= (r_bcol - 6'd1) == LAST_COL;
        end
    end

    always_comb begin
        o_stat.clr_last  = (r_bcol == LAST_COL);
        o_stat.ent_more  = (r_ent < r_count);
        o_stat.is_rect   = r_kind[1];
        case (r_kind)
            KIND_SMALL:  o_stat.ent_skip = (r_ey[4:0] != {1'b0, r_page});
            KIND_DOUBLE: o_stat.ent_skip = r_ey[7];
            default:     o_stat.ent_skip = 1'b0;
        endcase
        o_stat.chr_more  = (r_chr < r_len) && (r_cx < COLS);
        o_stat.pix_more  = r_kind[1] ? (r_col < {1'b0, r_xlim})
                                     : (r_sub < (w_small ? SMALL_COLS : DOUBLE_COLS));
        o_stat.col_ok    = (r_col < COLS);
        o_stat.emit_last = r_out_last;
    end

    assign o_col_byte  = r_out_byte;
    assign o_col_index = r_out_idx;
    assign o_col_last  = r_out_last;

endmodule

### rtl/core/display_list_page_renderer.sv
// Top level of the display list page renderer.
//  channel  | dir | tdata (low bit up)                       | tuser / tlast
//  s_axis   | in  | pos_x pos_y rect_w rect_h char_code page | tuser: req_type entry_kind
//  m_axis   | out | column_byte column_index                 | tlast: last_column
// A list request is taken while idle; a render clears the page, reads and latches each entry,
// reads and latches each character of a text entry, reads and writes back each drawn pixel
// column, steps over clipped columns, then reads each page column and offers it on the output
// while the output side is ready; a stall holds the column.
// One item is in work at a time, set by the sequencer, which takes a request only while idle.
// Reset (synchronous, active low) empties the list and idles the sequencer.
module display_list_page_renderer #(
    parameter int MAX_ENTRIES = 16,
    parameter int TEXT_LEN    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // pos_x, pos_y, rect_w, rect_h, char_code, page_index
    input  logic [3:0]  i_s_axis_tuser,   // req_type, entry_kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // column_byte, column_index
    output logic        o_m_axis_tlast
);
    import dlpr_pkg::*;

    t_req       w_req;
    t_cmd       w_cmd;
    t_stat      w_stat;
    logic [7:0] w_byte;
    logic [5:0] w_idx;
    logic       w_last;

    assign w_req.req_type   = i_s_axis_tuser[1:0];
    assign w_req.entry_kind = i_s_axis_tuser[3:2];
    assign w_req.pos_x      = i_s_axis_tdata[7:0];
    assign w_req.pos_y      = i_s_axis_tdata[15:8];
    assign w_req.rect_w     = i_s_axis_tdata[23:16];
    assign w_req.rect_h     = i_s_axis_tdata[31:24];
    assign w_req.char_code  = i_s_axis_tdata[39:32];
    assign w_req.page_index = i_s_axis_tdata[43:40];

    dlpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_is_render (w_req.req_type == REQ_RENDER),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    dlpr_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TEXT_LEN    (TEXT_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_col_byte  (w_byte),
        .o_col_index (w_idx),
        .o_col_last  (w_last)
    );

    assign o_m_axis_tdata = {2'b00, w_idx, w_byte};
    assign o_m_axis_tlast = w_last;

endmodule

### sim/display_list_page_renderer_checker.sv
// Checker: watches both streams, predicts page columns and compares them.
`timescale 1ns / 1ps

module display_list_page_renderer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // pos_x, pos_y, rect_w, rect_h, char_code, page_index
    input  logic [3:0]  i_s_axis_tuser,   // req_type, entry_kind
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // column_byte, column_index
    input  logic        i_m_axis_tlast,
    output int          o_failures,
    output int          o_pending
);
    import dlpr_pkg::*;

    localparam int MAX_ENTRIES = 16;
    localparam int TEXT_LEN    = 16;
    localparam int NCOLS       = 64;

    typedef struct packed {
        logic [7:0] pixels;
        logic [5:0] index;
        logic       last;
    } t_column;

    t_column    columns_due[$];
    int         failures;
    int         list_count;
    logic [1:0] list_kind [MAX_ENTRIES];
    logic [7:0] list_x    [MAX_ENTRIES];
    logic [7:0] list_y    [MAX_ENTRIES];
    logic [7:0] list_w    [MAX_ENTRIES];
    logic [7:0] list_h    [MAX_ENTRIES];
    int         list_len  [MAX_ENTRIES];
    logic [7:0] list_text [MAX_ENTRIES][TEXT_LEN];
    logic [7:0] page_px   [NCOLS];

    function automatic logic [7:0] font_column(logic [7:0] code, int k);
        int g;
        g = (code < GLYPH_FIRST || code > GLYPH_LAST) ? 0 : int'(code - GLYPH_FIRST);
        if (k > 4) return 8'h00;
        return FONT[g][39 - 8 * k -: 8];
    endfunction

    task automatic draw_small(int x, int y, logic [7:0] code, int page);
        logic [7:0] bits;
        int col, py;
        if (x >= NCOLS || y >= 128) return;
        for (int cx = 0; cx < 6; cx++) begin
            bits = font_column(code, cx);
            col  = x + cx;
            if (col >= NCOLS) continue;
            for (int by = 0; by < 8; by++) begin
                py = (y + by) & 255;
                if ((py >> 3) != page) continue;
                if (by < 7 && bits[by]) page_px[col][py & 7] = 1'b1;
                else page_px[col][py & 7] = 1'b0;
            end
        end
    endtask

    task automatic draw_double(int x, int y, logic [7:0] code, int page);
        logic [7:0] bits;
        int py, px;
        if (x >= NCOLS || y >= 128) return;
        for (int c = 0; c < 5; c++) begin
            bits = font_column(code, c);
            for (int r = 0; r < 7; r++) begin
                if (!bits[r]) continue;
                for (int dy = 0; dy < 2; dy++) begin
                    py = (y + r * 2 + dy) & 255;
                    if ((py >> 3) != page) continue;
                    for (int dx = 0; dx < 2; dx++) begin
                        px = x + c * 2 + dx;
                        if (px < NCOLS) page_px[px][py & 7] = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic draw_rect(int e, int page, bit fill);
        int top, bottom, ps, lo, hi, xend;
        logic [7:0] mask;
        top    = list_y[e];
        bottom = top + list_h[e];
        ps     = page * 8;
        mask   = 8'h00;
        if (top >= ps + 8 || bottom <= ps) return;
        lo = (top > ps) ? top : ps;
        hi = (bottom < ps + 8) ? bottom : ps + 8;
        for (int iy = lo; iy < hi; iy++) mask[iy & 7] = 1'b1;
        xend = (list_x[e] + list_w[e]) & 255;
        if (xend > NCOLS) xend = NCOLS;
        for (int ix = list_x[e]; ix < xend; ix++) begin
            if (fill) page_px[ix] = page_px[ix] | mask;
            else page_px[ix] = page_px[ix] & ~mask;
        end
    endtask

    task automatic render_page(int page);
        int x;
        t_column c;
        for (int i = 0; i < NCOLS; i++) page_px[i] = 8'h00;
        for (int e = 0; e < list_count; e++) begin
            x = list_x[e];
            case (list_kind[e])
                KIND_FILL:  draw_rect(e, page, 1'b1);
                KIND_ERASE: draw_rect(e, page, 1'b0);
                KIND_DOUBLE: begin
                    for (int i = 0; i < list_len[e] && x < NCOLS; i++, x += 12)
                        draw_double(x, list_y[e], list_text[e][i], page);
                end
                default: begin
                    for (int i = 0; i < list_len[e] && x < NCOLS; i++, x += 6)
                        draw_small(x, (list_y[e] * 8) & 255, list_text[e][i], page);
                end
            endcase
        end
        for (int i = 0; i < NCOLS; i++) begin
            c.pixels = page_px[i];
            c.index  = i[5:0];
            c.last   = (i == NCOLS - 1);
            columns_due.push_back(c);
        end
    endtask

    task automatic apply_request(logic [3:0] user, logic [47:0] data);
        int e;
        case (user[1:0])
            REQ_CLEAR: list_count = 0;
            REQ_OPEN: begin
                if (list_count < MAX_ENTRIES) begin
                    e = list_count;
                    list_kind[e] = user[3:2];
                    list_x[e]    = data[7:0];
                    list_y[e]    = data[15:8];
                    list_w[e]    = data[23:16];
                    list_h[e]    = data[31:24];
                    list_len[e]  = 0;
                    list_count++;
                end
            end
            REQ_APPEND: begin
                if (list_count > 0) begin
                    e = list_count - 1;
                    if (list_len[e] < TEXT_LEN - 1) begin
                        list_text[e][list_len[e]] = data[39:32];
                        list_len[e]++;
                    end
                end
            end
            default: render_page(int'(data[43:40]));
        endcase
    endtask

    task automatic check_column();
        t_column want;
        if (columns_due.size() == 0) begin
            $display("%0t: unexpected column word, got byte %h index %0d last %b", $time,
                     i_m_axis_tdata[7:0], i_m_axis_tdata[13:8], i_m_axis_tlast);
            failures++;
            return;
        end
        want = columns_due.pop_front();
        if (want.pixels !== i_m_axis_tdata[7:0] || want.index !== i_m_axis_tdata[13:8]
            || want.last !== i_m_axis_tlast) begin
            $display("%0t: expected byte %h index %0d last %b, got byte %h index %0d last %b",
                     $time, want.pixels, want.index, want.last,
                     i_m_axis_tdata[7:0], i_m_axis_tdata[13:8], i_m_axis_tlast);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_count = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) check_column();
            if (i_s_axis_tvalid && i_s_axis_tready) apply_request(i_s_axis_tuser, i_s_axis_tdata);
        end
        o_failures <= failures;
        o_pending  <= columns_due.size();
    end

endmodule

### sim/display_list_page_renderer_tb.sv
// Testbench top: drives requests and output stalls, reports the verdict.
`timescale 1ns / 1ps

module display_list_page_renderer_tb;
    import dlpr_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // pos_x, pos_y, rect_w, rect_h, char_code, page_index
    logic [3:0]  s_tuser;   // req_type, entry_kind
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // column_byte, column_index
    logic        m_tlast;
    int          failures;
    int          pending;
    int          burst_left;

    display_list_page_renderer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tlast(m_tlast)
    );

    display_list_page_renderer_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tlast(m_tlast),
        .o_failures(failures), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("FAIL display_list_page_renderer");
        $finish;
    end

    function automatic logic [47:0] pack_word(logic [7:0] x, logic [7:0] y, logic [7:0] w,
                                              logic [7:0] h, logic [7:0] ch, logic [3:0] pg);
        return {4'h0, pg, ch, h, w, y, x};
    endfunction

    task automatic send(logic [1:0] req, logic [1:0] kind, logic [47:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= {kind, req};
        s_tdata  <= data;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic open_entry(logic [1:0] kind, logic [7:0] x, logic [7:0] y,
                              logic [7:0] w, logic [7:0] h);
        send(REQ_OPEN, kind, pack_word(x, y, w, h, 8'($urandom), 4'($urandom)));
    endtask

    task automatic add_char(logic [7:0] ch);
        send(REQ_APPEND, 2'($urandom), pack_word(8'($urandom), 8'($urandom), 8'($urandom),
                                                 8'($urandom), ch, 4'($urandom)));
    endtask

    task automatic render(logic [3:0] pg);
        send(REQ_RENDER, 2'($urandom), pack_word(8'($urandom), 8'($urandom), 8'($urandom),
                                                 8'($urandom), 8'($urandom), pg));
    endtask

    // waits for the registered pending count to update first, so the count of the last accepted render is visible
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // output stall pattern, with one long hold to back up the input side
    initial begin
        int mode;
        m_tready <= 1'b0;
        repeat (30000) begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            m_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                                        : ($urandom_range(0, 3) == 0);
        end
        m_tready <= 1'b0;
        repeat (4000) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            m_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                                        : ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int r, kind, waited;
        burst_left = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, odd characters, clipping and wrap cases
        add_char(8'h41);
        open_entry(KIND_SMALL, 8'd0, 8'd0, 8'd0, 8'd0);
        add_char(8'h41);
        add_char(8'h00);
        add_char(8'h1F);
        add_char(8'h7F);
        add_char(8'h80);
        add_char(8'hFF);
        open_entry(KIND_DOUBLE, 8'd60, 8'd250, 8'hFF, 8'hFF);
        add_char(8'h57);
        add_char(8'h20);
        open_entry(KIND_DOUBLE, 8'd5, 8'd3, 8'd0, 8'd0);
        add_char(8'h40);
        open_entry(KIND_FILL, 8'd250, 8'd0, 8'd255, 8'd255);
        open_entry(KIND_FILL, 8'd10, 8'd4, 8'd255, 8'd9);
        open_entry(KIND_ERASE, 8'd12, 8'd6, 8'd8, 8'd3);
        add_char(8'h58);
        render(4'd0);
        render(4'd1);
        render(4'd15);
        open_entry(KIND_SMALL, 8'd61, 8'd255, 8'd0, 8'd0);
        repeat (16) add_char(8'h23);
        render(4'd15);
        send(REQ_CLEAR, KIND_ERASE, pack_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF));

        for (int n = 0; n < 220; n++) begin
            if (n == 100) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send(REQ_CLEAR, 2'($urandom), 48'({$urandom, $urandom}));
            end else if (r < 25) begin
                kind = $urandom_range(0, 3);
                open_entry(2'(kind),
                           8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 70)),
                           8'(($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 20)),
                           8'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 40)),
                           8'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 16)));
            end else if (r < 85) begin
                add_char(8'(($urandom_range(0, 4) == 0) ? $urandom
                                                        : $urandom_range(8'h20, 8'h7F)));
            end else begin
                render(4'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom));
            end
        end

        wait_drained();
        waited = 0;
        while (waited < 300) begin
            @(posedge i_clk);
            waited++;
        end
        if (failures == 0 && pending == 0) begin
            $display("PASS display_list_page_renderer");
        end else begin
            $display("FAIL display_list_page_renderer");
        end
        $finish;
    end

endmodule
